/* hdl/two_key_sorted_priority_list_defines.svh */
// ----------------------------------------------------------------------------
// two_key_sorted_priority_list_defines
// assertion macros for the sorted priority list
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_SORTED_PRIORITY_LIST_DEFINES_SVH
`define TWO_KEY_SORTED_PRIORITY_LIST_DEFINES_SVH

`ifndef ASSERT_OFF
`define TKSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TKSP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TKSP_ASSERT(label, prop, msg)
`define TKSP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* hdl/tksp_pkg.sv */
// ----------------------------------------------------------------------------
// tksp_pkg
// types and constants of the two-key sorted priority list
// ----------------------------------------------------------------------------
package tksp_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int ID_W   = 10;
	localparam int PRI_W  = 8;
	localparam int AGE_W  = 16;
	localparam int POS_W  = 6;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 6;
	localparam int OCC_W  = 7;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic [PRI_W-1:0] pri;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		logic ahead;
		logic id_hit;
	} cmp_t;

endpackage

/* hdl/tksp_cmp.sv */
// ----------------------------------------------------------------------------
// tksp_cmp
// shared key and id comparator for the list scan
// ----------------------------------------------------------------------------
module tksp_cmp (
	input  tksp_pkg::entry_t             ent,
	input  logic [tksp_pkg::PRI_W-1:0]   key_pri,
	input  logic [tksp_pkg::AGE_W-1:0]   key_age,
	input  logic [tksp_pkg::ID_W-1:0]    key_id,
	output tksp_pkg::cmp_t               res
);
	import tksp_pkg::*;

	// new entry goes in front of a lower priority, or same priority and lower age
	always_comb begin
		res.ahead  = (ent.pri < key_pri) || ((ent.pri == key_pri) && (ent.age < key_age));
		res.id_hit = (ent.id == key_id);
	end

endmodule

/* hdl/two_key_sorted_priority_list.sv */
// ----------------------------------------------------------------------------
// two_key_sorted_priority_list
// sorted list of entries ordered by priority then age, with insert,
// remove by id and read by position
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, registered-read memory of DEPTH
// entries and one comparator walks it. Each transfer is handled alone; an
// insert walks the list to its place and shifts the entries behind it down,
// a remove walks to the id, or to the end when it is not found, and closes
// the gap, a read fetches one position, and a full insert, a read past the
// end or an unused op go straight to the output. The walk is set by the one
// memory read and one write per cycle. One finished result can wait at the
// output while the next transfer is taken in.
`include "two_key_sorted_priority_list_defines.svh"

module two_key_sorted_priority_list (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// entry_id, priority_req, age, position
	input  logic [tksp_pkg::IN_DATA_W-1:0]    s_tdata,
	// op
	input  logic [tksp_pkg::OP_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// slot, occupancy, read_id, read_priority, read_age, zero pad
	output logic [tksp_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status
	output logic [tksp_pkg::STAT_W-1:0]       m_tuser
);
	import tksp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_MV_RD = 3'd3;
	localparam logic [2:0] S_MV_WR = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  at_q;
	logic [OP_W-1:0]   op_q;
	entry_t            req_q;
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  slot_q;
	logic              rd_ok_q;

	entry_t            mem [DEPTH];
	entry_t            rd_data_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              we;
	logic [IDX_W-1:0]  wa;
	entry_t            wd;
	logic [IDX_W-1:0]  nb;
	cmp_t              cmp;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [OCC_W-1:0]  out_occ_q;
	entry_t            out_ent_q;

	logic              accept;
	logic              out_free;
	logic              ins;
	logic              rm_done;
	entry_t            s_ent;
	logic [POS_W-1:0]  s_pos;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign ins      = (op_q == OP_INSERT);
	assign nb       = ins ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
	assign rm_done  = (CNT_W'(ptr_q) + CNT_W'(1)) >= count_q;

	assign s_ent.id  = s_tdata[9:0];
	assign s_ent.pri = s_tdata[17:10];
	assign s_ent.age = s_tdata[33:18];
	assign s_pos     = s_tdata[39:34];

	tksp_cmp u_cmp (
		.ent     (rd_data_q),
		.key_pri (req_q.pri),
		.key_age (req_q.age),
		.key_id  (req_q.id),
		.res     (cmp)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		we      = 1'b0;
		wa      = ptr_q;
		wd      = rd_data_q;
		case (state_q)
			S_RD: begin
				rd_en = (idx_q != count_q);
			end
			S_MV_RD: begin
				rd_addr = nb;
				rd_en   = ins ? (ptr_q != at_q) : !rm_done;
			end
			S_MV_WR: begin
				we = 1'b1;
			end
			S_PUT: begin
				we = 1'b1;
				wa = at_q;
				wd = req_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			ptr_q       <= '0;
			at_q        <= '0;
			status_q    <= ST_OK;
			slot_q      <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ok_q <= 1'b0;
						slot_q  <= '0;
						idx_q   <= (s_tuser == OP_READ) ? CNT_W'(s_pos) : '0;
						case (s_tuser)
							OP_INSERT: begin
								if (count_q == CNT_MAX) begin
									status_q <= ST_FULL;
									state_q  <= S_OUT;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_RD;
								end
							end
							OP_REMOVE: begin
								status_q <= ST_OK;
								state_q  <= S_RD;
							end
							OP_READ: begin
								if (CMP_W'(s_pos) >= CMP_W'(count_q)) begin
									status_q <= ST_EMPTY;
									state_q  <= S_OUT;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_RD;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_RD: begin
					if (idx_q == count_q) begin
						if (ins) begin
							at_q    <= IDX_W'(idx_q);
							ptr_q   <= IDX_W'(count_q);
							state_q <= S_MV_RD;
						end else begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_OUT;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					case (op_q)
						OP_INSERT: begin
							if (cmp.ahead) begin
								at_q    <= IDX_W'(idx_q);
								ptr_q   <= IDX_W'(count_q);
								state_q <= S_MV_RD;
							end else begin
								idx_q   <= idx_q + CNT_W'(1);
								state_q <= S_RD;
							end
						end
						OP_REMOVE: begin
							if (cmp.id_hit) begin
								at_q    <= IDX_W'(idx_q);
								ptr_q   <= IDX_W'(idx_q);
								state_q <= S_MV_RD;
							end else begin
								idx_q   <= idx_q + CNT_W'(1);
								state_q <= S_RD;
							end
						end
						default: begin
							rd_ok_q <= 1'b1;
							slot_q  <= IDX_W'(idx_q);
							state_q <= S_OUT;
						end
					endcase
				end
				S_MV_RD: begin
					if (ins) begin
						state_q <= (ptr_q == at_q) ? S_PUT : S_MV_WR;
					end else if (rm_done) begin
						count_q <= count_q - CNT_W'(1);
						slot_q  <= at_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MV_WR;
					end
				end
				S_MV_WR: begin
					ptr_q   <= nb;
					state_q <= S_MV_RD;
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					slot_q  <= at_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			req_q <= s_ent;
		end
		if ((state_q == S_OUT) && out_free) begin
			out_status_q <= status_q;
			out_slot_q   <= SLOT_W'(slot_q);
			out_occ_q    <= OCC_W'(count_q);
			out_ent_q    <= rd_ok_q ? rd_data_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_ent_q.age, out_ent_q.pri, out_ent_q.id, out_occ_q, out_slot_q};

	`TKSP_ASSERT_NEVER(a_count_bound, count_q > CNT_MAX, "entry count above depth")
	`TKSP_ASSERT(a_count_at_end, (count_q != $past(count_q)) |-> (state_q == S_OUT), "count moved mid op")
	`TKSP_ASSERT(a_busy_after_take, (s_tvalid && s_tready) |=> (state_q != S_IDLE), "idle after transfer")
	`TKSP_ASSERT_NEVER(a_ptr_range, ((state_q == S_MV_RD) || (state_q == S_MV_WR)) && (CNT_W'(ptr_q) > count_q), "move past list end")

endmodule
